### rtl/core/dform_load_store_unit_core_assert.svh
// assertion macros for the load/store unit top level
// expects clk_i and rst_ni in the scope that uses them
`ifndef DFORM_LOAD_STORE_UNIT_CORE_ASSERT_SVH
`define DFORM_LOAD_STORE_UNIT_CORE_ASSERT_SVH

// same-cycle implication
`define DLSU_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dlsu assertion failed");

// next-cycle implication
`define DLSU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dlsu assertion failed");

`endif

### rtl/core/dlsu_pkg.sv
// shared types, codes and decode function for the d-form load/store unit
// no dependencies
`default_nettype none

package dlsu_pkg;

  localparam int unsigned MAIN_RAM_BYTES_DEF = 65536;
  localparam int unsigned EXT_RAM_BYTES_DEF  = 65536;
  localparam int unsigned OFF_W              = 16;

  localparam logic [1:0] REQ_EXEC  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam logic [5:0] OPC_LWZ = 6'd32;
  localparam logic [5:0] OPC_LBZ = 6'd34;
  localparam logic [5:0] OPC_STW = 6'd36;
  localparam logic [5:0] OPC_STB = 6'd38;
  localparam logic [5:0] OPC_LHZ = 6'd40;
  localparam logic [5:0] OPC_LHA = 6'd42;
  localparam logic [5:0] OPC_STH = 6'd44;

  localparam logic [1:0] CFG_MAIN_BASE = 2'd0;
  localparam logic [1:0] CFG_MAIN_MASK = 2'd1;
  localparam logic [1:0] CFG_EXT_BASE  = 2'd2;
  localparam logic [1:0] CFG_EXT_MASK  = 2'd3;

  localparam logic [31:0] MAIN_BASE_RST = 32'h8000_0000;
  localparam logic [15:0] MAIN_MASK_RST = 16'hFFFF;
  localparam logic [31:0] EXT_BASE_RST  = 32'h9000_0000;
  localparam logic [15:0] EXT_MASK_RST  = 16'hFFFF;

  localparam logic [31:0] PC_STEP = 32'd4;

  typedef enum logic [1:0] {
    RES_NONE,
    RES_DONE,
    RES_REG,
    RES_LOAD
  } res_kind_e;

  typedef struct packed {
    logic       known;
    logic       is_load;
    logic       is_store;
    logic       sign_ext;
    logic [1:0] nbytes_m1;
  } op_info_t;

  typedef struct packed {
    logic      capture;
    logic      rf_rd_en;
    logic      rf_rd_base;
    logic      rf_wr_wval;
    logic      rf_wr_load;
    logic      pc_upd;
    logic      ea_calc;
    logic      win_calc;
    logic      cnt_clr;
    logic      cnt_inc;
    logic      mem_access;
    logic      acc_shift;
    logic      res_set;
    res_kind_e res_kind;
    logic      out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic       access_ok;
    logic       is_load;
    logic       last_byte;
    logic       out_free;
  } dp_stat_t;

  function automatic op_info_t dlsu_decode(input logic [5:0] opc);
    op_info_t info;
    info = '0;
    unique case (opc)
      OPC_LWZ: info = '{known: 1'b1, is_load: 1'b1, is_store: 1'b0, sign_ext: 1'b0,
                        nbytes_m1: 2'd3};
      OPC_LBZ: info = '{known: 1'b1, is_load: 1'b1, is_store: 1'b0, sign_ext: 1'b0,
                        nbytes_m1: 2'd0};
      OPC_LHZ: info = '{known: 1'b1, is_load: 1'b1, is_store: 1'b0, sign_ext: 1'b0,
                        nbytes_m1: 2'd1};
      OPC_LHA: info = '{known: 1'b1, is_load: 1'b1, is_store: 1'b0, sign_ext: 1'b1,
                        nbytes_m1: 2'd1};
      OPC_STW: info = '{known: 1'b1, is_load: 1'b0, is_store: 1'b1, sign_ext: 1'b0,
                        nbytes_m1: 2'd3};
      OPC_STB: info = '{known: 1'b1, is_load: 1'b0, is_store: 1'b1, sign_ext: 1'b0,
                        nbytes_m1: 2'd0};
      OPC_STH: info = '{known: 1'b1, is_load: 1'b0, is_store: 1'b1, sign_ext: 1'b0,
                        nbytes_m1: 2'd1};
      default: info = '0;
    endcase
    return info;
  endfunction

endpackage

`default_nettype wire

### rtl/core/dlsu_byte_index.sv
// two-stage reduction of a masked byte offset modulo the ram size
// uses dlsu_pkg for the offset width
`default_nettype none

module dlsu_byte_index #(
  parameter int unsigned RAM_BYTES = dlsu_pkg::MAIN_RAM_BYTES_DEF
) (
  input  logic                         clk_i,
  input  logic [dlsu_pkg::OFF_W-1:0]   off_i,
  output logic [$clog2(RAM_BYTES)-1:0] idx_o
);
  import dlsu_pkg::*;

  localparam int unsigned IdxW = $clog2(RAM_BYTES);

  generate
    if (RAM_BYTES >= (2 ** OFF_W)) begin : g_direct
      logic [OFF_W-1:0] off_q;
      logic [IdxW-1:0]  idx_q;

      always_ff @(posedge clk_i) begin
        off_q <= off_i;
        idx_q <= IdxW'(off_q);
      end

      assign idx_o = idx_q;
    end else begin : g_reduce
      // exact quotient by reciprocal for offsets below 2^16
      localparam logic [32:0] Recip =
        33'(((64'd1 << 32) + 64'(RAM_BYTES) - 64'd1) / 64'(RAM_BYTES));

      logic [OFF_W-1:0] off_q;
      logic [48:0]      prod_q;
      logic [16:0]      quot;
      logic [31:0]      rem;
      logic [IdxW-1:0]  idx_q;

      assign quot = prod_q[48:32];
      assign rem  = 32'(off_q) - (32'(quot) * 32'(RAM_BYTES));

      always_ff @(posedge clk_i) begin
        off_q  <= off_i;
        prod_q <= 49'(off_i) * 49'(Recip);
        idx_q  <= rem[IdxW-1:0];
      end

      assign idx_o = idx_q;
    end
  endgenerate

endmodule

`default_nettype wire

### rtl/core/dlsu_controller.sv
// request sequencer of the load/store unit
// uses dlsu_pkg command and status types
`default_nettype none

module dlsu_controller (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  dlsu_pkg::dp_stat_t stat_i,
  output dlsu_pkg::ctl_cmd_t cmd_o
);
  import dlsu_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_START = 4'd1;
  localparam logic [3:0] S_RDRES = 4'd2;
  localparam logic [3:0] S_EA    = 4'd3;
  localparam logic [3:0] S_WIN   = 4'd4;
  localparam logic [3:0] S_BOFF  = 4'd5;
  localparam logic [3:0] S_BIDX  = 4'd6;
  localparam logic [3:0] S_BMEM  = 4'd7;
  localparam logic [3:0] S_BLOAD = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  logic [3:0] state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_START;
        end
      end
      S_START: begin
        unique case (stat_i.req)
          REQ_WRITE: begin
            cmd_o.rf_wr_wval = 1'b1;
            cmd_o.res_set    = 1'b1;
            cmd_o.res_kind   = RES_DONE;
            state_d          = S_DONE;
          end
          REQ_READ: begin
            cmd_o.rf_rd_en = 1'b1;
            state_d        = S_RDRES;
          end
          REQ_EXEC: begin
            cmd_o.pc_upd     = 1'b1;
            cmd_o.rf_rd_en   = 1'b1;
            cmd_o.rf_rd_base = 1'b1;
            state_d          = S_EA;
          end
          default: begin
            cmd_o.res_set  = 1'b1;
            cmd_o.res_kind = RES_NONE;
            state_d        = S_DONE;
          end
        endcase
      end
      S_RDRES: begin
        cmd_o.res_set  = 1'b1;
        cmd_o.res_kind = RES_REG;
        state_d        = S_DONE;
      end
      S_EA: begin
        cmd_o.ea_calc  = 1'b1;
        cmd_o.rf_rd_en = 1'b1;
        state_d        = S_WIN;
      end
      S_WIN: begin
        cmd_o.win_calc = 1'b1;
        if (stat_i.access_ok) begin
          cmd_o.cnt_clr = 1'b1;
          state_d       = S_BOFF;
        end else begin
          cmd_o.res_set  = 1'b1;
          cmd_o.res_kind = RES_NONE;
          state_d        = S_DONE;
        end
      end
      S_BOFF: state_d = S_BIDX;
      S_BIDX: state_d = S_BMEM;
      S_BMEM: begin
        cmd_o.mem_access = 1'b1;
        if (stat_i.is_load) begin
          state_d = S_BLOAD;
        end else if (stat_i.last_byte) begin
          state_d = S_FIN;
        end else begin
          cmd_o.cnt_inc = 1'b1;
          state_d       = S_BOFF;
        end
      end
      S_BLOAD: begin
        cmd_o.acc_shift = 1'b1;
        if (stat_i.last_byte) begin
          state_d = S_FIN;
        end else begin
          cmd_o.cnt_inc = 1'b1;
          state_d       = S_BOFF;
        end
      end
      S_FIN: begin
        cmd_o.res_set = 1'b1;
        if (stat_i.is_load) begin
          cmd_o.rf_wr_load = 1'b1;
          cmd_o.res_kind   = RES_LOAD;
        end else begin
          cmd_o.res_kind = RES_DONE;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/dlsu_datapath.sv
// register file, windows, byte rams and result register of the load/store unit
// uses dlsu_pkg and dlsu_byte_index
`default_nettype none

module dlsu_datapath #(
  parameter int unsigned MAIN_RAM_BYTES = dlsu_pkg::MAIN_RAM_BYTES_DEF,
  parameter int unsigned EXT_RAM_BYTES  = dlsu_pkg::EXT_RAM_BYTES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dlsu_pkg::ctl_cmd_t cmd_i,
  output dlsu_pkg::dp_stat_t stat_o,
  input  logic [1:0]         req_type_i,
  input  logic [5:0]         opcode_i,
  input  logic [4:0]         data_reg_i,
  input  logic [4:0]         base_reg_i,
  input  logic signed [15:0] displacement_i,
  input  logic [31:0]        instr_pc_i,
  input  logic               write_pc_i,
  input  logic [31:0]        write_value_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output logic [31:0]        result_value_o,
  output logic               handled_o,
  output logic [31:0]        pc_value_o,
  output logic [31:0]        next_pc_value_o
);
  import dlsu_pkg::*;

  localparam int unsigned MainIdxW = $clog2(MAIN_RAM_BYTES);
  localparam int unsigned ExtIdxW  = $clog2(EXT_RAM_BYTES);

  // captured request
  logic [1:0]  req_q;
  logic [5:0]  opc_q;
  logic [4:0]  rd_q;
  logic [4:0]  ra_q;
  logic [15:0] disp_q;
  logic [31:0] ipc_q;
  logic        wpc_q;
  logic [31:0] wval_q;

  logic [31:0] main_base_q, ext_base_q;
  logic [15:0] main_mask_q, ext_mask_q;
  logic [31:0] pc_q, npc_q;

  logic [31:0] rf_mem [32];
  logic [31:0] rf_vld_q;
  logic [31:0] rf_rd_q;
  logic        rf_rvld_q;
  logic [31:0] rf_val;
  logic [4:0]  rf_raddr;
  logic        rf_we;
  logic [31:0] rf_wdata;

  logic [31:0] ea_q;
  logic [31:0] base_val;
  logic [31:0] main_diff, ext_diff;
  logic        main_hit, ext_hit;
  logic        sel_q;
  logic [15:0] off_q, mask_q;
  logic [31:0] st_data_q;
  logic [1:0]  cnt_q;
  logic [31:0] acc_q;
  op_info_t    op;

  logic [OFF_W-1:0]    byte_off;
  logic [MainIdxW-1:0] main_idx;
  logic [ExtIdxW-1:0]  ext_idx;
  logic [31:0]         st_shift;
  logic [7:0]          main_mem [MAIN_RAM_BYTES];
  logic [7:0]          ext_mem [EXT_RAM_BYTES];
  logic [7:0]          main_rd_q, ext_rd_q, mem_byte;
  logic                main_we, main_re, ext_we, ext_re;
  logic [31:0]         load_val;

  logic [31:0] res_value_q;
  logic        res_handled_q;
  logic        out_valid_q;
  logic        out_free;
  logic [31:0] out_value_q, out_pc_q, out_npc_q;
  logic        out_handled_q;

  assign op = dlsu_decode(opc_q);

  // register file read, unwritten entries read as zero
  assign rf_raddr = cmd_i.rf_rd_base ? ra_q : rd_q;
  assign rf_val   = rf_rvld_q ? rf_rd_q : '0;
  assign base_val = (ra_q == '0) ? '0 : rf_val;
  assign rf_we    = cmd_i.rf_wr_wval | cmd_i.rf_wr_load;
  assign rf_wdata = cmd_i.rf_wr_load ? load_val : wval_q;

  // window match, main first
  assign main_diff = ea_q - main_base_q;
  assign ext_diff  = ea_q - ext_base_q;
  assign main_hit  = (ea_q >= main_base_q) && (main_diff <= {16'b0, main_mask_q});
  assign ext_hit   = (ea_q >= ext_base_q) && (ext_diff <= {16'b0, ext_mask_q});

  assign byte_off = (off_q + {14'b0, cnt_q}) & mask_q;
  assign st_shift = st_data_q >> {(op.nbytes_m1 - cnt_q), 3'b000};
  assign mem_byte = sel_q ? ext_rd_q : main_rd_q;
  assign load_val = (op.sign_ext && acc_q[15]) ? {16'hFFFF, acc_q[15:0]} : acc_q;

  assign main_we = cmd_i.mem_access && !sel_q && op.is_store;
  assign main_re = cmd_i.mem_access && !sel_q && op.is_load;
  assign ext_we  = cmd_i.mem_access && sel_q && op.is_store;
  assign ext_re  = cmd_i.mem_access && sel_q && op.is_load;

  assign out_free = !out_valid_q || !out_stall_i;

  assign stat_o.req       = req_q;
  assign stat_o.access_ok = (main_hit || ext_hit) && op.known;
  assign stat_o.is_load   = op.is_load;
  assign stat_o.last_byte = (cnt_q == op.nbytes_m1);
  assign stat_o.out_free  = out_free;

  dlsu_byte_index #(
    .RAM_BYTES(MAIN_RAM_BYTES)
  ) u_main_index (
    .clk_i(clk_i),
    .off_i(byte_off),
    .idx_o(main_idx)
  );

  dlsu_byte_index #(
    .RAM_BYTES(EXT_RAM_BYTES)
  ) u_ext_index (
    .clk_i(clk_i),
    .off_i(byte_off),
    .idx_o(ext_idx)
  );

  always_ff @(posedge clk_i) begin
    if (main_we) begin
      main_mem[main_idx] <= st_shift[7:0];
    end
    if (main_re) begin
      main_rd_q <= main_mem[main_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ext_we) begin
      ext_mem[ext_idx] <= st_shift[7:0];
    end
    if (ext_re) begin
      ext_rd_q <= ext_mem[ext_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      rf_mem[rd_q] <= rf_wdata;
    end
    if (cmd_i.rf_rd_en) begin
      rf_rd_q <= rf_mem[rf_raddr];
    end
  end

  // control state, configuration and architectural registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_base_q <= MAIN_BASE_RST;
      main_mask_q <= MAIN_MASK_RST;
      ext_base_q  <= EXT_BASE_RST;
      ext_mask_q  <= EXT_MASK_RST;
      pc_q        <= '0;
      npc_q       <= '0;
      rf_vld_q    <= '0;
      rf_rvld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_MAIN_BASE: main_base_q <= cfg_wdata_i;
          CFG_MAIN_MASK: main_mask_q <= cfg_wdata_i[15:0];
          CFG_EXT_BASE:  ext_base_q  <= cfg_wdata_i;
          CFG_EXT_MASK:  ext_mask_q  <= cfg_wdata_i[15:0];
        endcase
      end
      if (cmd_i.pc_upd && wpc_q) begin
        pc_q  <= ipc_q;
        npc_q <= ipc_q + PC_STEP;
      end
      if (rf_we) begin
        rf_vld_q[rd_q] <= 1'b1;
      end
      if (cmd_i.rf_rd_en) begin
        rf_rvld_q <= rf_vld_q[rf_raddr];
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q  <= req_type_i;
      opc_q  <= opcode_i;
      rd_q   <= data_reg_i;
      ra_q   <= base_reg_i;
      disp_q <= displacement_i;
      ipc_q  <= instr_pc_i;
      wpc_q  <= write_pc_i;
      wval_q <= write_value_i;
    end
    if (cmd_i.ea_calc) begin
      ea_q <= base_val + {{16{disp_q[15]}}, disp_q};
    end
    if (cmd_i.win_calc) begin
      sel_q     <= !main_hit;
      off_q     <= main_hit ? (main_diff[15:0] & main_mask_q) : (ext_diff[15:0] & ext_mask_q);
      mask_q    <= main_hit ? main_mask_q : ext_mask_q;
      st_data_q <= rf_val;
    end
    if (cmd_i.cnt_clr) begin
      cnt_q <= '0;
      acc_q <= '0;
    end else begin
      if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + 2'd1;
      end
      if (cmd_i.acc_shift) begin
        acc_q <= {acc_q[23:0], mem_byte};
      end
    end
    if (cmd_i.res_set) begin
      unique case (cmd_i.res_kind)
        RES_NONE: begin
          res_value_q   <= '0;
          res_handled_q <= 1'b0;
        end
        RES_DONE: begin
          res_value_q   <= '0;
          res_handled_q <= 1'b1;
        end
        RES_REG: begin
          res_value_q   <= rf_val;
          res_handled_q <= 1'b1;
        end
        RES_LOAD: begin
          res_value_q   <= load_val;
          res_handled_q <= 1'b1;
        end
        default: begin
          res_value_q   <= '0;
          res_handled_q <= 1'b0;
        end
      endcase
    end
    if (cmd_i.out_load) begin
      out_value_q   <= res_value_q;
      out_handled_q <= res_handled_q;
      out_pc_q      <= pc_q;
      out_npc_q     <= npc_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign result_value_o  = out_value_q;
  assign handled_o       = out_handled_q;
  assign pc_value_o      = out_pc_q;
  assign next_pc_value_o = out_npc_q;

endmodule

`default_nettype wire

### rtl/core/dform_load_store_unit_core.sv
// request kinds: register write, register read, window miss or unknown opcode, and store
// or load of n bytes; stores and loads go one byte at a time through the single byte port
// of each ram and the two-stage byte index per byte.
// one request in flight: the next is accepted the cycle after the result register loads.
// reset: window registers to defaults, pc and next pc to zero, register file reads zero;
// ram contents are not initialized.
`default_nettype none

module dform_load_store_unit_core #(
  parameter int unsigned MAIN_RAM_BYTES = dlsu_pkg::MAIN_RAM_BYTES_DEF,
  parameter int unsigned EXT_RAM_BYTES  = dlsu_pkg::EXT_RAM_BYTES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         req_type_i,
  input  logic [5:0]         opcode_i,
  input  logic [4:0]         data_reg_i,
  input  logic [4:0]         base_reg_i,
  input  logic signed [15:0] displacement_i,
  input  logic [31:0]        instr_pc_i,
  input  logic               write_pc_i,
  input  logic [31:0]        write_value_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_wdata_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [31:0]        result_value_o,
  output logic               handled_o,
  output logic [31:0]        pc_value_o,
  output logic [31:0]        next_pc_value_o
);
  import dlsu_pkg::*;

`include "dform_load_store_unit_core_assert.svh"

  ctl_cmd_t ctl_cmd;
  dp_stat_t dp_stat;

  dlsu_controller u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .stat_i    (dp_stat),
    .cmd_o     (ctl_cmd)
  );

  dlsu_datapath #(
    .MAIN_RAM_BYTES(MAIN_RAM_BYTES),
    .EXT_RAM_BYTES (EXT_RAM_BYTES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (ctl_cmd),
    .stat_o         (dp_stat),
    .req_type_i     (req_type_i),
    .opcode_i       (opcode_i),
    .data_reg_i     (data_reg_i),
    .base_reg_i     (base_reg_i),
    .displacement_i (displacement_i),
    .instr_pc_i     (instr_pc_i),
    .write_pc_i     (write_pc_i),
    .write_value_i  (write_value_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .result_value_o (result_value_o),
    .handled_o      (handled_o),
    .pc_value_o     (pc_value_o),
    .next_pc_value_o(next_pc_value_o)
  );

  `DLSU_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)
  `DLSU_ASSERT_IMP(a_no_result_overwrite, ctl_cmd.out_load, !(out_valid_o && out_stall_i))
  `DLSU_ASSERT_IMP(a_single_rf_write, ctl_cmd.rf_wr_wval, !ctl_cmd.rf_wr_load)

endmodule

`default_nettype wire
